@@ src/utx_pkg.sv @@
`default_nettype none

package utx_pkg;

  localparam int UTX_DEPTH = 64;
  localparam int BYTE_W    = 8;
  localparam int FRAME_W   = BYTE_W + 2;
  localparam int TDATA_W   = 8;

  // item kind carried on s_tuser
  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  // bit positions of the result fields in m_tdata
  localparam int OUT_LINE = 0;
  localparam int OUT_ACC  = 1;
  localparam int OUT_FULL = 2;
  localparam int OUT_BUSY = 3;
  localparam int OUT_W    = 4;

  localparam logic [FRAME_W-1:0] FRAME_STOP_BIT = FRAME_W'(10'h200);

  function automatic logic [FRAME_W-1:0] build_frame(input logic [BYTE_W-1:0] b);
    build_frame = FRAME_STOP_BIT | {1'b0, b, 1'b0};
  endfunction

endpackage

`default_nettype wire

@@ src/utx_ram.sv @@
`default_nettype none

module utx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first: a read of the address being written returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ src/uart_tx_fifo_serializer.sv @@
`default_nettype none
// channel | dir | tvalid/tready      | tdata                             | tuser
// s       | in  | s_tvalid/s_tready  | data_byte[7:0]                    | cmd (0 push, 1 tick)
// m       | out | m_tvalid/m_tready  | tx_line,push_accepted,fifo_full,  | -
//         |     |                    | busy_res in [3:0], zeros above    |
//
// One beat per cycle while s_tready is high; the result is valid the next cycle.
// The byte ring sits in a RAM whose read port always prefetches the entry at the
// next read pointer; a push into that same entry is forwarded for one cycle.
// Reset clears pointers and shifter and sets the line high; the RAM is not cleared.
// s_tready drops only while a result waits in the output register and m_tready is low.

module uart_tx_fifo_serializer #(
  parameter int DEPTH = utx_pkg::UTX_DEPTH
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [utx_pkg::TDATA_W-1:0] s_tdata,  // [7:0] data_byte
  input  wire logic                        s_tuser,  // [0] cmd
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [utx_pkg::TDATA_W-1:0] m_tdata   // [0] tx_line [1] push_accepted
                                                     // [2] fifo_full [3] busy_res
);

  import utx_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    adv = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  logic [PTR_W-1:0]   wr_ptr, wr_ptr_next;
  logic [PTR_W-1:0]   rd_ptr, rd_ptr_next;
  logic [FRAME_W-1:0] shifter, shifter_next;
  logic               line, line_next;
  logic               fwd_hit;
  logic [BYTE_W-1:0]  fwd_byte;
  logic [BYTE_W-1:0]  ram_q;
  logic [BYTE_W-1:0]  head_byte;
  logic               accept;
  logic               push_ok;
  logic               is_tick;
  logic               full_next;
  logic               busy_next;
  logic [OUT_W-1:0]   res;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign is_tick  = (cmd_t'(s_tuser) == CMD_TICK);
  assign push_ok  = accept && !is_tick && (adv(wr_ptr) != rd_ptr);

  assign head_byte = fwd_hit ? fwd_byte : ram_q;

  always_comb begin
    wr_ptr_next  = wr_ptr;
    rd_ptr_next  = rd_ptr;
    shifter_next = shifter;
    line_next    = line;
    if (push_ok) begin
      wr_ptr_next = adv(wr_ptr);
    end else if (accept && is_tick) begin
      if (shifter != '0) begin
        line_next    = shifter[0];
        shifter_next = shifter >> 1;
      end else if (wr_ptr != rd_ptr) begin
        rd_ptr_next  = adv(rd_ptr);
        shifter_next = build_frame(head_byte);
      end
    end
  end

  assign full_next = (adv(wr_ptr_next) == rd_ptr_next);
  assign busy_next = (shifter_next != '0) || (wr_ptr_next != rd_ptr_next);

  always_comb begin
    res           = '0;
    res[OUT_LINE] = line_next;
    res[OUT_ACC]  = push_ok;
    res[OUT_FULL] = full_next;
    res[OUT_BUSY] = busy_next;
  end

  utx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (push_ok),
    .wr_addr (wr_ptr),
    .wr_data (s_tdata[BYTE_W-1:0]),
    .rd_addr (rd_ptr_next),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      shifter  <= '0;
      line     <= 1'b1;
      fwd_hit  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      wr_ptr  <= wr_ptr_next;
      rd_ptr  <= rd_ptr_next;
      shifter <= shifter_next;
      line    <= line_next;
      // RAM returns stale data when the prefetch hits the entry written now
      fwd_hit <= push_ok && (wr_ptr == rd_ptr_next);
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_byte <= s_tdata[BYTE_W-1:0];
    if (accept) begin
      m_tdata <= TDATA_W'(res);
    end
  end

endmodule

`default_nettype wire

@@ src/utx_checker.sv @@
`default_nettype none

module utx_sva (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_tvalid,
  input wire logic                        s_tready,
  input wire logic [utx_pkg::TDATA_W-1:0] s_tdata,
  input wire logic                        s_tuser,
  input wire logic                        m_tvalid,
  input wire logic                        m_tready,
  input wire logic [utx_pkg::TDATA_W-1:0] m_tdata
);

  import utx_pkg::*;

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

  // every input beat produces a result beat next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> m_tvalid)
    else $error("input beat without result");

  // a tick never reports a stored byte
  a_tick_acc: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && cmd_t'(s_tuser) == CMD_TICK) |=> !m_tdata[OUT_ACC])
    else $error("tick reported push_accepted");

  // a full ring is never idle
  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[OUT_FULL]) |-> m_tdata[OUT_BUSY])
    else $error("fifo_full without busy_res");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // s_tdata is not checked here beyond its presence on the port
  logic unused_tdata;
  assign unused_tdata = ^s_tdata;

endmodule

bind uart_tx_fifo_serializer utx_sva u_utx_sva (.*);

`default_nettype wire
